// File: src/ang_pkg.sv
// Shared types, constants and helper functions of the audio noise gate.
package ang_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_IDX_W     = 3;
    localparam int SAMPLE_W     = 16;
    localparam int MAG_W        = 16;
    localparam int GAIN_W       = 17;
    localparam int COEFF_W      = 16;
    localparam int HOLD_W       = 21;
    localparam int COUNT_W      = 22;
    localparam int MAKEUP_W     = 17;
    localparam int CHANS_W      = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 21;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN = 17'd65536;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    localparam logic [MAG_W-1:0]    OPEN_LEVEL_RESET   = 16'd1642;
    localparam logic [MAG_W-1:0]    CLOSE_LEVEL_RESET  = 16'd32768;
    localparam logic [COEFF_W-1:0]  ATTACK_POLE_RESET  = 16'd65386;
    localparam logic [COEFF_W-1:0]  RELEASE_POLE_RESET = 16'd65524;
    localparam logic [HOLD_W-1:0]   ATTACK_HOLD_RESET  = 21'd0;
    localparam logic [HOLD_W-1:0]   RELEASE_HOLD_RESET = 21'd9600;
    localparam logic [MAKEUP_W-1:0] MAKEUP_GAIN_RESET  = 17'd1024;
    localparam logic [CHANS_W-1:0]  CHANNELS_RESET     = 4'd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [GAIN_W-1:0] gain_t;

    typedef struct packed {
        logic [MAG_W-1:0]    open_level;
        logic [MAG_W-1:0]    close_level;
        logic [COEFF_W-1:0]  attack_pole;
        logic [COEFF_W-1:0]  release_pole;
        logic [HOLD_W-1:0]   attack_hold_samples;
        logic [HOLD_W-1:0]   release_hold_samples;
        logic [MAKEUP_W-1:0] makeup_gain;
        logic [CHANS_W-1:0]  channels_in_use;
    } cfg_t;

    typedef struct packed {
        sample_t [MAX_CHANNELS-1:0] samples;
        gain_t                      gain;
    } frame_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPEN_LEVEL   = 3'd0,
        REG_CLOSE_LEVEL  = 3'd1,
        REG_ATTACK_POLE  = 3'd2,
        REG_RELEASE_POLE = 3'd3,
        REG_ATTACK_HOLD  = 3'd4,
        REG_RELEASE_HOLD = 3'd5,
        REG_MAKEUP_GAIN  = 3'd6,
        REG_CHANNELS     = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_PEAK,
        FS_MUL,
        FS_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_RUN,
        BS_DONE
    } back_state_t;

    typedef enum logic [1:0] {
        GOP_KEEP,
        GOP_ATTACK,
        GOP_RELEASE
    } gain_op_t;

    // Zero channels count as one, anything above the lane count as all lanes.
    function automatic logic [CHANS_W-1:0] active_channels(input logic [CHANS_W-1:0] n);
        logic [CHANS_W-1:0] r;
        if (n == '0) begin
            r = CHANS_W'(1);
        end else if (n > CHANS_W'(MAX_CHANNELS)) begin
            r = CHANS_W'(MAX_CHANNELS);
        end else begin
            r = n;
        end
        return r;
    endfunction

    // Magnitude of a Q1.15 sample; the most negative code maps to 32768.
    function automatic logic [MAG_W-1:0] magnitude(input sample_t s);
        logic [MAG_W-1:0] u;
        u = MAG_W'(s);
        return u[MAG_W-1] ? MAG_W'(~u + MAG_W'(1)) : u;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? COUNT_MAX : COUNT_W'(c + COUNT_W'(1));
    endfunction

endpackage

// File: src/ang_if.sv
// Valid/ready channel interfaces for input frames and gated result frames.
interface ang_in_if;
    logic                  valid;
    logic                  ready;
    logic signed [15:0]    in_ch0;
    logic signed [15:0]    in_ch1;
    logic signed [15:0]    in_ch2;
    logic signed [15:0]    in_ch3;
    logic signed [15:0]    in_ch4;
    logic signed [15:0]    in_ch5;
    logic signed [15:0]    in_ch6;
    logic signed [15:0]    in_ch7;

    modport source (
        output valid, in_ch0, in_ch1, in_ch2, in_ch3, in_ch4, in_ch5, in_ch6, in_ch7,
        input  ready
    );
    modport sink (
        input  valid, in_ch0, in_ch1, in_ch2, in_ch3, in_ch4, in_ch5, in_ch6, in_ch7,
        output ready
    );
endinterface

interface ang_out_if;
    logic                  valid;
    logic                  ready;
    logic signed [15:0]    out_ch0;
    logic signed [15:0]    out_ch1;
    logic signed [15:0]    out_ch2;
    logic signed [15:0]    out_ch3;
    logic signed [15:0]    out_ch4;
    logic signed [15:0]    out_ch5;
    logic signed [15:0]    out_ch6;
    logic signed [15:0]    out_ch7;
    logic [16:0]           gate_gain;

    modport source (
        output valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5, out_ch6,
               out_ch7, gate_gain,
        input  ready
    );
    modport sink (
        input  valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5, out_ch6,
               out_ch7, gate_gain,
        output ready
    );
endinterface

// File: src/ang_front.sv
// Front end: takes frames, finds the peak, runs the hold counters and the gain ramp.
module ang_front (
    input  logic            clk,
    input  logic            rst_n,
    input  ang_pkg::cfg_t   cfg,
    ang_in_if.sink          audio,
    input  logic            q_full,
    output logic            q_push,
    output ang_pkg::frame_t q_data
);

    ang_pkg::front_state_t state_reg;
    ang_pkg::front_state_t state_next;

    ang_pkg::sample_t [ang_pkg::MAX_CHANNELS-1:0] samples_reg;
    ang_pkg::gain_t                               last_gain_reg;
    logic [ang_pkg::COUNT_W-1:0]                  open_cnt_reg;
    logic [ang_pkg::COUNT_W-1:0]                  open_cnt_next;
    logic [ang_pkg::COUNT_W-1:0]                  close_cnt_reg;
    logic [ang_pkg::COUNT_W-1:0]                  close_cnt_next;
    ang_pkg::gain_op_t                            op_reg;
    ang_pkg::gain_op_t                            op_next;
    logic [ang_pkg::COEFF_W-1:0]                  coeff_reg;
    logic [ang_pkg::COEFF_W-1:0]                  coeff_next;
    ang_pkg::gain_t                               operand_reg;
    ang_pkg::gain_t                               operand_next;
    logic [ang_pkg::COEFF_W+ang_pkg::GAIN_W-1:0]  prod_reg;

    logic [ang_pkg::CHANS_W-1:0] n_active;
    logic [ang_pkg::MAG_W-1:0]   peak;
    logic [ang_pkg::MAG_W-1:0]   close_eff;
    ang_pkg::gain_t              gain_new;

    // Peak magnitude over the active channels of the captured frame.
    always_comb
    begin
        logic [ang_pkg::MAG_W-1:0] mag;
        n_active = ang_pkg::active_channels(cfg.channels_in_use);
        peak     = '0;
        mag      = '0;
        for (int c = 0; c < ang_pkg::MAX_CHANNELS; c++)
        begin
            mag = ang_pkg::magnitude(samples_reg[c]);
            if (ang_pkg::CHANS_W'(c) < n_active && mag > peak)
            begin
                peak = mag;
            end
        end
    end

    // Classify the peak against the two thresholds and pick the ramp operands.
    always_comb
    begin
        logic [ang_pkg::COUNT_W-1:0] inc;
        close_eff = (cfg.close_level < cfg.open_level) ?
                    cfg.close_level : cfg.open_level;
        open_cnt_next  = '0;
        close_cnt_next = '0;
        op_next        = ang_pkg::GOP_KEEP;
        coeff_next     = cfg.attack_pole;
        operand_next   = last_gain_reg;
        inc            = '0;
        if (peak > cfg.open_level)
        begin
            inc           = ang_pkg::sat_inc(open_cnt_reg);
            open_cnt_next = inc;
            operand_next  = ang_pkg::UNITY_GAIN - last_gain_reg;
            if (inc > ang_pkg::COUNT_W'(cfg.attack_hold_samples))
            begin
                op_next = ang_pkg::GOP_ATTACK;
            end
        end
        else if (peak < close_eff)
        begin
            inc            = ang_pkg::sat_inc(close_cnt_reg);
            close_cnt_next = inc;
            coeff_next     = cfg.release_pole;
            if (inc > ang_pkg::COUNT_W'(cfg.release_hold_samples))
            begin
                op_next = ang_pkg::GOP_RELEASE;
            end
        end
    end

    always_comb
    begin
        case (op_reg)
            ang_pkg::GOP_ATTACK:
                gain_new = ang_pkg::UNITY_GAIN - {1'b0, prod_reg[31:16]};
            ang_pkg::GOP_RELEASE:
                gain_new = prod_reg[32:16];
            default:
                gain_new = last_gain_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ang_pkg::FS_IDLE:
                if (audio.valid)
                begin
                    state_next = ang_pkg::FS_PEAK;
                end
            ang_pkg::FS_PEAK:
                state_next = ang_pkg::FS_MUL;
            ang_pkg::FS_MUL:
                state_next = ang_pkg::FS_PUSH;
            ang_pkg::FS_PUSH:
                if (!q_full)
                begin
                    state_next = ang_pkg::FS_IDLE;
                end
        endcase
    end

    always_comb
    begin
        audio.ready = 1'b0;
        q_push      = 1'b0;
        unique case (state_reg)
            ang_pkg::FS_IDLE: audio.ready = 1'b1;
            ang_pkg::FS_PEAK: ;
            ang_pkg::FS_MUL:  ;
            ang_pkg::FS_PUSH: q_push = !q_full;
        endcase
    end

    assign q_data.samples = samples_reg;
    assign q_data.gain    = gain_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ang_pkg::FS_IDLE;
            last_gain_reg <= '0;
            open_cnt_reg  <= '0;
            close_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ang_pkg::FS_PEAK)
            begin
                open_cnt_reg  <= open_cnt_next;
                close_cnt_reg <= close_cnt_next;
            end
            if (q_push)
            begin
                last_gain_reg <= gain_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (audio.valid && audio.ready)
        begin
            samples_reg[0] <= audio.in_ch0;
            samples_reg[1] <= audio.in_ch1;
            samples_reg[2] <= audio.in_ch2;
            samples_reg[3] <= audio.in_ch3;
            samples_reg[4] <= audio.in_ch4;
            samples_reg[5] <= audio.in_ch5;
            samples_reg[6] <= audio.in_ch6;
            samples_reg[7] <= audio.in_ch7;
        end
        if (state_reg == ang_pkg::FS_PEAK)
        begin
            op_reg      <= op_next;
            coeff_reg   <= coeff_next;
            operand_reg <= operand_next;
        end
        if (state_reg == ang_pkg::FS_MUL)
        begin
            prod_reg <= (ang_pkg::COEFF_W + ang_pkg::GAIN_W)'(coeff_reg) *
                        (ang_pkg::COEFF_W + ang_pkg::GAIN_W)'(operand_reg);
        end
    end

endmodule

// File: src/ang_queue.sv
// Two-entry frame queue between the front end and the output scaler.
module ang_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ang_pkg::frame_t push_data,
    output logic            full,
    input  logic            pop,
    output ang_pkg::frame_t pop_data,
    output logic            empty
);

    ang_pkg::frame_t entries_reg [ang_pkg::QUEUE_DEPTH];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full     = (count_reg == 2'(ang_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/ang_back.sv
// Back end: scales each active channel by gain and makeup, then holds the result.
module ang_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ang_pkg::cfg_t   cfg,
    input  logic            q_empty,
    output logic            q_pop,
    input  ang_pkg::frame_t q_data,
    ang_out_if.source       gated
);

    localparam int P1_W = ang_pkg::MAG_W + ang_pkg::GAIN_W - 1;
    localparam int P2_W = P1_W + ang_pkg::MAKEUP_W - 1;
    localparam logic [P2_W:0] ROUND_HALF = (P2_W + 1)'(1) << 25;

    ang_pkg::back_state_t state_reg;
    ang_pkg::back_state_t state_next;

    ang_pkg::frame_t                              frame_reg;
    logic [ang_pkg::CHANS_W-1:0]                  issue_reg;
    logic                                         v1_reg;
    logic                                         v2_reg;
    logic [ang_pkg::CH_IDX_W-1:0]                 idx1_reg;
    logic [ang_pkg::CH_IDX_W-1:0]                 idx2_reg;
    logic                                         neg1_reg;
    logic                                         neg2_reg;
    logic [P1_W-1:0]                              p1_reg;
    logic [P2_W-1:0]                              p2_reg;
    ang_pkg::sample_t [ang_pkg::MAX_CHANNELS-1:0] buf_reg;
    logic                                         out_valid_reg;
    ang_pkg::sample_t [ang_pkg::MAX_CHANNELS-1:0] out_samples_reg;
    ang_pkg::gain_t                               out_gain_reg;

    logic [ang_pkg::CHANS_W-1:0]  n_active;
    logic                         issue_fire;
    logic                         out_free;
    logic                         out_load;
    ang_pkg::sample_t             issue_sample;

    // Round half away from zero on the magnitude, then clamp to the Q1.15 range.
    function automatic ang_pkg::sample_t round_sat(input logic [P2_W-1:0] p, input logic neg);
        logic [P2_W:0]                sum;
        logic [P2_W-26:0]             q;
        logic [ang_pkg::SAMPLE_W-1:0] m;
        sum = {1'b0, p} + ROUND_HALF;
        q   = sum[P2_W:26];
        if (neg)
        begin
            m = (q > (P2_W - 25)'(32768)) ? 16'h8000 : q[15:0];
            m = ~m + 16'd1;
        end
        else
        begin
            m = (q > (P2_W - 25)'(32767)) ? 16'h7fff : q[15:0];
        end
        return ang_pkg::sample_t'(m);
    endfunction

    assign n_active     = ang_pkg::active_channels(cfg.channels_in_use);
    assign issue_sample = frame_reg.samples[issue_reg[ang_pkg::CH_IDX_W-1:0]];
    assign issue_fire   = (state_reg == ang_pkg::BS_RUN) && (issue_reg < n_active);
    assign out_free     = !out_valid_reg || gated.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ang_pkg::BS_IDLE:
                if (!q_empty)
                begin
                    state_next = ang_pkg::BS_RUN;
                end
            ang_pkg::BS_RUN:
                if (!issue_fire && !v1_reg && !v2_reg)
                begin
                    state_next = ang_pkg::BS_DONE;
                end
            ang_pkg::BS_DONE:
                if (out_free)
                begin
                    state_next = ang_pkg::BS_IDLE;
                end
            default:
                state_next = ang_pkg::BS_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ang_pkg::BS_IDLE: q_pop = !q_empty;
            ang_pkg::BS_RUN:  ;
            ang_pkg::BS_DONE: out_load = out_free;
            default:          ;
        endcase
    end

    assign gated.valid     = out_valid_reg;
    assign gated.out_ch0   = out_samples_reg[0];
    assign gated.out_ch1   = out_samples_reg[1];
    assign gated.out_ch2   = out_samples_reg[2];
    assign gated.out_ch3   = out_samples_reg[3];
    assign gated.out_ch4   = out_samples_reg[4];
    assign gated.out_ch5   = out_samples_reg[5];
    assign gated.out_ch6   = out_samples_reg[6];
    assign gated.out_ch7   = out_samples_reg[7];
    assign gated.gate_gain = out_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ang_pkg::BS_IDLE;
            issue_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue_fire;
            v2_reg    <= v1_reg;
            if (q_pop)
            begin
                issue_reg <= '0;
            end
            else if (issue_fire)
            begin
                issue_reg <= issue_reg + ang_pkg::CHANS_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (gated.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            frame_reg <= q_data;
        end
        if (issue_fire)
        begin
            p1_reg   <= P1_W'(ang_pkg::magnitude(issue_sample)) * P1_W'(frame_reg.gain);
            idx1_reg <= issue_reg[ang_pkg::CH_IDX_W-1:0];
            neg1_reg <= issue_sample[ang_pkg::SAMPLE_W-1];
        end
        if (v1_reg)
        begin
            p2_reg   <= P2_W'(p1_reg) * P2_W'(cfg.makeup_gain);
            idx2_reg <= idx1_reg;
            neg2_reg <= neg1_reg;
        end
        if (v2_reg)
        begin
            buf_reg[idx2_reg] <= round_sat(p2_reg, neg2_reg);
        end
        if (out_load)
        begin
            for (int c = 0; c < ang_pkg::MAX_CHANNELS; c++)
            begin
                out_samples_reg[c] <= (ang_pkg::CHANS_W'(c) < n_active) ? buf_reg[c] : '0;
            end
            out_gain_reg <= frame_reg.gain;
        end
    end

endmodule

// File: src/audio_noise_gate_hold.sv
// Top level of the audio noise gate with hysteresis and hold.
//
// Usage: frames of eight Q1.15 samples enter on the audio channel, a valid/ready
// request per frame. Only the first channels_in_use channels count; the others
// are ignored and come out as zero. Each gated frame leaves on the gated
// channel together with the Q1.16 gain that was applied to it.
// After the accepting edge a frame passes through the front end (peak and
// hold counters, coefficient multiply, gain update) and then the back end,
// which scales the active channels one after another; the back end's two
// shared multipliers take one channel a cycle. Each part works on one frame
// at a time. A two-entry queue separates the two parts, so the front end keeps
// taking requests while a result waits on the gated channel. When the receiver
// stalls, the result stays in the output register, the queue fills and the
// audio channel then drops ready.
// Reset clears the gain and both hold counters to zero and loads the register
// defaults. Registers are written through cfg_write/cfg_index/cfg_data; the
// user must write them only while the block has no frame in flight, which the
// block itself does not enforce.
module audio_noise_gate_hold (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ang_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ang_pkg::CFG_DATA_W-1:0]     cfg_data,
    ang_in_if.sink                             audio,
    ang_out_if.source                          gated
);

    logic [ang_pkg::MAG_W-1:0]    open_level_reg;
    logic [ang_pkg::MAG_W-1:0]    close_level_reg;
    logic [ang_pkg::COEFF_W-1:0]  attack_pole_reg;
    logic [ang_pkg::COEFF_W-1:0]  release_pole_reg;
    logic [ang_pkg::HOLD_W-1:0]   attack_hold_reg;
    logic [ang_pkg::HOLD_W-1:0]   release_hold_reg;
    logic [ang_pkg::MAKEUP_W-1:0] makeup_gain_reg;
    logic [ang_pkg::CHANS_W-1:0]  channels_reg;

    ang_pkg::cfg_t   cfg;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    ang_pkg::frame_t q_in;
    ang_pkg::frame_t q_out;

    // Register file. Each write keeps the low bits that the register holds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_level_reg   <= ang_pkg::OPEN_LEVEL_RESET;
            close_level_reg  <= ang_pkg::CLOSE_LEVEL_RESET;
            attack_pole_reg  <= ang_pkg::ATTACK_POLE_RESET;
            release_pole_reg <= ang_pkg::RELEASE_POLE_RESET;
            attack_hold_reg  <= ang_pkg::ATTACK_HOLD_RESET;
            release_hold_reg <= ang_pkg::RELEASE_HOLD_RESET;
            makeup_gain_reg  <= ang_pkg::MAKEUP_GAIN_RESET;
            channels_reg     <= ang_pkg::CHANNELS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (ang_pkg::cfg_index_t'(cfg_index))
                ang_pkg::REG_OPEN_LEVEL:
                    open_level_reg <= cfg_data[ang_pkg::MAG_W-1:0];
                ang_pkg::REG_CLOSE_LEVEL:
                    close_level_reg <= cfg_data[ang_pkg::MAG_W-1:0];
                ang_pkg::REG_ATTACK_POLE:
                    attack_pole_reg <= cfg_data[ang_pkg::COEFF_W-1:0];
                ang_pkg::REG_RELEASE_POLE:
                    release_pole_reg <= cfg_data[ang_pkg::COEFF_W-1:0];
                ang_pkg::REG_ATTACK_HOLD:
                    attack_hold_reg <= cfg_data[ang_pkg::HOLD_W-1:0];
                ang_pkg::REG_RELEASE_HOLD:
                    release_hold_reg <= cfg_data[ang_pkg::HOLD_W-1:0];
                ang_pkg::REG_MAKEUP_GAIN:
                    makeup_gain_reg <= cfg_data[ang_pkg::MAKEUP_W-1:0];
                ang_pkg::REG_CHANNELS:
                    channels_reg <= cfg_data[ang_pkg::CHANS_W-1:0];
            endcase
        end
    end

    assign cfg.open_level           = open_level_reg;
    assign cfg.close_level          = close_level_reg;
    assign cfg.attack_pole          = attack_pole_reg;
    assign cfg.release_pole         = release_pole_reg;
    assign cfg.attack_hold_samples  = attack_hold_reg;
    assign cfg.release_hold_samples = release_hold_reg;
    assign cfg.makeup_gain          = makeup_gain_reg;
    assign cfg.channels_in_use      = channels_reg;

    // The front end owns the gate state: stored gain and both hold counters.
    ang_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .audio  (audio),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    // Each queue entry carries the raw samples and the gain chosen for them.
    ang_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // The back end scales one channel per cycle and owns the output register.
    ang_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_data  (q_out),
        .gated   (gated)
    );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for audio_noise_gate_hold: directed and random frames against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // One input frame as it sits on the audio channel, lane 0 in the low bits.
    typedef ang_pkg::sample_t [ang_pkg::MAX_CHANNELS-1:0] pcm_frame_t;

    // Level class of a run of random frames, relative to the live thresholds.
    typedef enum int {
        LEVEL_LOUD,
        LEVEL_QUIET,
        LEVEL_BETWEEN
    } level_kind_t;

    localparam int     FULL_SCALE  = 32768;
    localparam longint UNITY       = 65536;
    localparam int     RAND_PHASES = 10;
    localparam int     PHASE_ITEMS = 160;

    logic clk = 1'b0;
    logic rst_n;
    logic                           cfg_write;
    logic [ang_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ang_pkg::CFG_DATA_W-1:0] cfg_data;

    ang_in_if  audio_ch();
    ang_out_if gated_ch();

    audio_noise_gate_hold u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .audio     (audio_ch),
        .gated     (gated_ch)
    );

    always #6 clk = ~clk;

    // Frames waiting to be offered, and gated frames the block still owes us.
    pcm_frame_t      pcm_backlog[$];
    ang_pkg::frame_t gated_frames_due[$];

    // Our own view of the register file and of the gain state of the gate.
    ang_pkg::cfg_t               cfg_shadow;
    ang_pkg::gain_t              gate_level;
    logic [ang_pkg::COUNT_W-1:0] open_run;
    logic [ang_pkg::COUNT_W-1:0] close_run;

    pcm_frame_t      frame_on_bus;
    ang_pkg::frame_t got_frame;
    ang_pkg::frame_t want_frame;
    int              send_gap;
    int              recv_stall;
    bit              steady_flow;
    int              chan_idx;
    int              phase_idx;

    int frames_queued;
    int requests_taken;
    int results_seen;
    int mismatches;
    int settings_used;
    int open_frames;
    int close_frames;
    int between_frames;
    int gain_rises;
    int gain_falls;

    // Number of lanes the block actually looks at: zero counts as one and
    // anything above the lane count as all lanes.
    function automatic int lanes_in_use();
        int n;
        n = int'(cfg_shadow.channels_in_use);
        if (n < 1) n = 1;
        if (n > ang_pkg::MAX_CHANNELS) n = ang_pkg::MAX_CHANNELS;
        return n;
    endfunction

    // Works out the gated frame for one accepted request and advances the
    // gain and hold state exactly as the block must.
    function automatic ang_pkg::frame_t gate_frame(input pcm_frame_t x);
        ang_pkg::frame_t r;
        int     lanes;
        int     peak;
        int     mag;
        int     v;
        int     close_eff;
        int     c;
        longint g;
        longint prod;
        longint q;
        lanes = lanes_in_use();
        peak  = 0;
        for (c = 0; c < lanes; c++)
        begin
            v   = int'($signed(x[c]));
            mag = (v < 0) ? -v : v;
            if (mag > peak) peak = mag;
        end
        // The close threshold never sits above the open threshold.
        close_eff = (cfg_shadow.close_level < cfg_shadow.open_level) ?
                    int'(cfg_shadow.close_level) : int'(cfg_shadow.open_level);
        g = longint'(gate_level);
        if (peak > int'(cfg_shadow.open_level))
        begin
            open_frames++;
            open_run  = (open_run == ang_pkg::COUNT_MAX) ? open_run : open_run + 1'b1;
            close_run = '0;
            if (open_run > cfg_shadow.attack_hold_samples)
            begin
                // The remaining distance to unity is truncated, so unity is reached.
                g = UNITY - ((longint'(cfg_shadow.attack_pole) * (UNITY - g)) >>> 16);
            end
        end
        else if (peak < close_eff)
        begin
            close_frames++;
            open_run  = '0;
            close_run = (close_run == ang_pkg::COUNT_MAX) ? close_run : close_run + 1'b1;
            if (close_run > cfg_shadow.release_hold_samples)
            begin
                g = (longint'(cfg_shadow.release_pole) * g) >>> 16;
            end
        end
        else
        begin
            between_frames++;
            open_run  = '0;
            close_run = '0;
        end
        if (g > longint'(gate_level)) gain_rises++;
        if (g < longint'(gate_level)) gain_falls++;
        gate_level = ang_pkg::gain_t'(g);

        // Scale by gain and makeup, round half away from zero, then saturate.
        for (c = 0; c < ang_pkg::MAX_CHANNELS; c++)
        begin
            if (c < lanes)
            begin
                v    = int'($signed(x[c]));
                mag  = (v < 0) ? -v : v;
                prod = longint'(mag) * g * longint'(cfg_shadow.makeup_gain);
                q    = (prod + (longint'(1) <<< 25)) >>> 26;
                if (v < 0)
                begin
                    if (q > FULL_SCALE) q = FULL_SCALE;
                    r.samples[c] = ang_pkg::sample_t'(-q);
                end
                else
                begin
                    if (q > FULL_SCALE - 1) q = FULL_SCALE - 1;
                    r.samples[c] = ang_pkg::sample_t'(q);
                end
            end
            else
            begin
                r.samples[c] = '0;
            end
        end
        r.gain = gate_level;
        return r;
    endfunction

    function automatic void flag_field(input string field, input longint want,
                                       input longint got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("result %0d, %s: expected %0d, got %0d", results_seen, field, want, got);
        end
    endfunction

    // Mostly short pauses, a few long ones, none at all while steady_flow is set.
    function automatic int pick_idle();
        int roll;
        if (steady_flow) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A sample of the given magnitude with a random sign; full scale is
    // only reachable as the most negative code.
    function automatic ang_pkg::sample_t signed_level(input int mag);
        if (mag >= FULL_SCALE) return ang_pkg::sample_t'(-FULL_SCALE);
        return ($urandom_range(0, 1) != 0) ? ang_pkg::sample_t'(-mag) :
                                             ang_pkg::sample_t'(mag);
    endfunction

    function automatic void push_pcm(input pcm_frame_t f);
        pcm_backlog.push_back(f);
        frames_queued++;
    endfunction

    task automatic queue_lanes(input int a0, input int a1, input int a2, input int a3,
                               input int a4, input int a5, input int a6, input int a7);
        pcm_frame_t f;
        f[0] = ang_pkg::sample_t'(a0);
        f[1] = ang_pkg::sample_t'(a1);
        f[2] = ang_pkg::sample_t'(a2);
        f[3] = ang_pkg::sample_t'(a3);
        f[4] = ang_pkg::sample_t'(a4);
        f[5] = ang_pkg::sample_t'(a5);
        f[6] = ang_pkg::sample_t'(a6);
        f[7] = ang_pkg::sample_t'(a7);
        push_pcm(f);
    endtask

    // One register write. The data bits above the register's width carry
    // random junk, which the block has to drop.
    task automatic set_reg(input ang_pkg::cfg_index_t idx, input int unsigned value);
        int                             width;
        logic [ang_pkg::CFG_DATA_W-1:0] data;
        case (idx) inside
            ang_pkg::REG_OPEN_LEVEL, ang_pkg::REG_CLOSE_LEVEL:
                width = ang_pkg::MAG_W;
            ang_pkg::REG_ATTACK_POLE, ang_pkg::REG_RELEASE_POLE:
                width = ang_pkg::COEFF_W;
            ang_pkg::REG_ATTACK_HOLD, ang_pkg::REG_RELEASE_HOLD:
                width = ang_pkg::HOLD_W;
            ang_pkg::REG_MAKEUP_GAIN:
                width = ang_pkg::MAKEUP_W;
            default:
                width = ang_pkg::CHANS_W;
        endcase
        data = ang_pkg::CFG_DATA_W'(($urandom << width) | value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            ang_pkg::REG_OPEN_LEVEL:
                cfg_shadow.open_level = data[ang_pkg::MAG_W-1:0];
            ang_pkg::REG_CLOSE_LEVEL:
                cfg_shadow.close_level = data[ang_pkg::MAG_W-1:0];
            ang_pkg::REG_ATTACK_POLE:
                cfg_shadow.attack_pole = data[ang_pkg::COEFF_W-1:0];
            ang_pkg::REG_RELEASE_POLE:
                cfg_shadow.release_pole = data[ang_pkg::COEFF_W-1:0];
            ang_pkg::REG_ATTACK_HOLD:
                cfg_shadow.attack_hold_samples = data[ang_pkg::HOLD_W-1:0];
            ang_pkg::REG_RELEASE_HOLD:
                cfg_shadow.release_hold_samples = data[ang_pkg::HOLD_W-1:0];
            ang_pkg::REG_MAKEUP_GAIN:
                cfg_shadow.makeup_gain = data[ang_pkg::MAKEUP_W-1:0];
            default:
                cfg_shadow.channels_in_use = data[ang_pkg::CHANS_W-1:0];
        endcase
    endtask

    // Rewrites the whole register file; only called while nothing is in flight.
    task automatic program_regs(input int unsigned open_lvl, input int unsigned close_lvl,
                                input int unsigned atk, input int unsigned rel,
                                input int unsigned atk_hold, input int unsigned rel_hold,
                                input int unsigned makeup, input int unsigned chans);
        set_reg(ang_pkg::REG_OPEN_LEVEL, open_lvl);
        set_reg(ang_pkg::REG_CLOSE_LEVEL, close_lvl);
        set_reg(ang_pkg::REG_ATTACK_POLE, atk);
        set_reg(ang_pkg::REG_RELEASE_POLE, rel);
        set_reg(ang_pkg::REG_ATTACK_HOLD, atk_hold);
        set_reg(ang_pkg::REG_RELEASE_HOLD, rel_hold);
        set_reg(ang_pkg::REG_MAKEUP_GAIN, makeup);
        set_reg(ang_pkg::REG_CHANNELS, chans);
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    function automatic int unsigned pick_coeff();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return 0;
        if (roll < 20) return 65535;
        if (roll < 50) return $urandom_range(0, 65535);
        return $urandom_range(50000, 65535);
    endfunction

    // Holds are mostly short so that the ramps actually get to run.
    function automatic int unsigned pick_hold();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return $urandom_range(0, 6);
        if (roll < 90) return $urandom_range(7, 40);
        if (roll < 95) return 2097151;
        return $urandom_range(0, 2097151);
    endfunction

    task automatic program_random_setting();
        int unsigned open_lvl;
        int unsigned close_lvl;
        int unsigned makeup;
        int unsigned chans;
        int          roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)       open_lvl = 0;
        else if (roll < 16) open_lvl = FULL_SCALE;
        else if (roll < 22) open_lvl = $urandom_range(FULL_SCALE + 1, 65535);
        else                open_lvl = $urandom_range(200, 24000);
        // Now and then a close threshold above the open one, to exercise the clamp.
        close_lvl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) :
                                                  $urandom_range(0, open_lvl);
        roll = $urandom_range(0, 99);
        if (roll < 70)      makeup = $urandom_range(1024, 4096);
        else if (roll < 76) makeup = 0;
        else if (roll < 82) makeup = 65536;
        else if (roll < 88) makeup = 131071;
        else                makeup = $urandom_range(0, 131071);
        chans = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        program_regs(open_lvl, close_lvl, pick_coeff(), pick_coeff(), pick_hold(), pick_hold(),
                     makeup, chans);
    endtask

    // Random frames come in runs of one level class, some long enough to get past
    // the hold counters, with some plain noise frames mixed in. Lanes the
    // block ignores carry full random data.
    task automatic queue_random_phase(input int count);
        pcm_frame_t  f;
        level_kind_t kind;
        int          lanes;
        int          open_lvl;
        int          close_eff;
        int          lo;
        int          hi;
        int          mag;
        int          lead;
        int          run_left;
        int          roll;
        int          k;
        int          c;
        lanes     = lanes_in_use();
        open_lvl  = int'(cfg_shadow.open_level);
        close_eff = (cfg_shadow.close_level < cfg_shadow.open_level) ?
                    int'(cfg_shadow.close_level) : open_lvl;
        run_left  = 0;
        kind      = LEVEL_LOUD;
        for (k = 0; k < count; k++)
        begin
            if (run_left == 0)
            begin
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) :
                                                         $urandom_range(1, 12);
                roll = $urandom_range(0, 99);
                if (roll < 40)      kind = LEVEL_LOUD;
                else if (roll < 80) kind = LEVEL_QUIET;
                else                kind = LEVEL_BETWEEN;
            end
            run_left--;
            if ($urandom_range(0, 9) == 0)
            begin
                for (c = 0; c < ang_pkg::MAX_CHANNELS; c++)
                begin
                    f[c] = ang_pkg::sample_t'($urandom);
                end
            end
            else
            begin
                case (kind)
                    LEVEL_LOUD:
                    begin
                        lo = open_lvl + 1;
                        hi = FULL_SCALE;
                    end
                    LEVEL_QUIET:
                    begin
                        lo = 0;
                        hi = close_eff - 1;
                    end
                    default:
                    begin
                        lo = close_eff;
                        hi = open_lvl;
                    end
                endcase
                if (hi > FULL_SCALE) hi = FULL_SCALE;
                // A class the thresholds make unreachable falls back to any level.
                if (lo > hi)
                begin
                    lo = 0;
                    hi = FULL_SCALE;
                end
                mag  = $urandom_range(hi, lo);
                lead = $urandom_range(0, lanes - 1);
                for (c = 0; c < ang_pkg::MAX_CHANNELS; c++)
                begin
                    if (c == lead)      f[c] = signed_level(mag);
                    else if (c < lanes) f[c] = signed_level($urandom_range(0, mag));
                    else                f[c] = ang_pkg::sample_t'($urandom);
                end
            end
            push_pcm(f);
        end
    endtask

    // Waits until every queued frame has been taken and every result has come back.
    task automatic drain();
        while (requests_taken != frames_queued || gated_frames_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Request driver. The item on the bus is predicted at the edge where it is
    // accepted; a new item (or a gap) is chosen whenever the bus is free.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            audio_ch.valid  <= 1'b0;
            audio_ch.in_ch0 <= '0;
            audio_ch.in_ch1 <= '0;
            audio_ch.in_ch2 <= '0;
            audio_ch.in_ch3 <= '0;
            audio_ch.in_ch4 <= '0;
            audio_ch.in_ch5 <= '0;
            audio_ch.in_ch6 <= '0;
            audio_ch.in_ch7 <= '0;
        end
        else
        begin
            if (audio_ch.valid && audio_ch.ready)
            begin
                gated_frames_due.push_back(gate_frame(frame_on_bus));
                requests_taken++;
            end
            if (!audio_ch.valid || audio_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    audio_ch.valid <= 1'b0;
                end
                else if (pcm_backlog.size() != 0)
                begin
                    frame_on_bus = pcm_backlog.pop_front();
                    audio_ch.valid  <= 1'b1;
                    audio_ch.in_ch0 <= frame_on_bus[0];
                    audio_ch.in_ch1 <= frame_on_bus[1];
                    audio_ch.in_ch2 <= frame_on_bus[2];
                    audio_ch.in_ch3 <= frame_on_bus[3];
                    audio_ch.in_ch4 <= frame_on_bus[4];
                    audio_ch.in_ch5 <= frame_on_bus[5];
                    audio_ch.in_ch6 <= frame_on_bus[6];
                    audio_ch.in_ch7 <= frame_on_bus[7];
                    send_gap = pick_idle();
                end
                else
                begin
                    audio_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. It stalls the gated channel at random and compares each
    // accepted result, field by field, with the oldest frame still owed.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            gated_ch.ready <= 1'b0;
        end
        else
        begin
            if (gated_ch.valid && gated_ch.ready)
            begin
                got_frame.samples[0] = gated_ch.out_ch0;
                got_frame.samples[1] = gated_ch.out_ch1;
                got_frame.samples[2] = gated_ch.out_ch2;
                got_frame.samples[3] = gated_ch.out_ch3;
                got_frame.samples[4] = gated_ch.out_ch4;
                got_frame.samples[5] = gated_ch.out_ch5;
                got_frame.samples[6] = gated_ch.out_ch6;
                got_frame.samples[7] = gated_ch.out_ch7;
                got_frame.gain       = gated_ch.gate_gain;
                if (gated_frames_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d arrived with no request outstanding, gain %0d",
                                 results_seen, got_frame.gain);
                    end
                end
                else
                begin
                    want_frame = gated_frames_due.pop_front();
                    for (chan_idx = 0; chan_idx < ang_pkg::MAX_CHANNELS; chan_idx++)
                    begin
                        if (got_frame.samples[chan_idx] !== want_frame.samples[chan_idx])
                        begin
                            flag_field($sformatf("out_ch%0d", chan_idx),
                                       $signed(want_frame.samples[chan_idx]),
                                       $signed(got_frame.samples[chan_idx]));
                        end
                    end
                    if (got_frame.gain !== want_frame.gain)
                    begin
                        flag_field("gate_gain", want_frame.gain, got_frame.gain);
                    end
                end
                results_seen++;
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                gated_ch.ready <= 1'b0;
            end
            else
            begin
                gated_ch.ready <= 1'b1;
                recv_stall = pick_idle();
            end
        end
    end

    initial
    begin
        // The channel signals get their values from the driver and the monitor
        // while reset is held; the register port starts out quiet.
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        cfg_shadow = '{
            open_level:           ang_pkg::OPEN_LEVEL_RESET,
            close_level:          ang_pkg::CLOSE_LEVEL_RESET,
            attack_pole:          ang_pkg::ATTACK_POLE_RESET,
            release_pole:         ang_pkg::RELEASE_POLE_RESET,
            attack_hold_samples:  ang_pkg::ATTACK_HOLD_RESET,
            release_hold_samples: ang_pkg::RELEASE_HOLD_RESET,
            makeup_gain:          ang_pkg::MAKEUP_GAIN_RESET,
            channels_in_use:      ang_pkg::CHANNELS_RESET
        };
        gate_level     = '0;
        open_run       = '0;
        close_run      = '0;
        send_gap       = 0;
        recv_stall     = 0;
        steady_flow    = 1'b0;
        frames_queued  = 0;
        requests_taken = 0;
        results_seen   = 0;
        mismatches     = 0;
        settings_used  = 1;
        open_frames    = 0;
        close_frames   = 0;
        between_frames = 0;
        gain_rises     = 0;
        gain_falls     = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults straight out of reset: two lanes, so lanes 2..7
        // carry junk that must be ignored. Quiet, both full-scale extremes,
        // a peak exactly at the open threshold (held between) and one above it.
        queue_lanes(0, 0, 5, -5, 7, -7, 9, -9);
        queue_lanes(32767, -32768, 100, -100, 32767, -32768, 1, -1);
        queue_lanes(-32768, 0, 32767, 32767, 32767, 32767, 32767, 32767);
        queue_lanes(1642, -1642, 30000, -30000, 0, 0, 0, 0);
        queue_lanes(-1643, 1, -32768, -32768, -32768, -32768, -32768, -32768);
        drain();

        // All lanes, hold of one frame, instant ramps and a makeup of 65536:
        // the second loud frame jumps to unity and the outputs saturate both
        // ways. A close threshold above the open one is clamped, so only a peak
        // of exactly 20000 holds between.
        program_regs(20000, 30000, 0, 0, 1, 1, 65536, 8);
        queue_lanes(20001, -20001, 32767, -32768, 1, -1, 0, 12345);
        queue_lanes(20001, -20001, 32767, -32768, 1, -1, 0, 12345);
        queue_lanes(-200, 7, 32767, -32768, 300, -300, 1, -1);
        queue_lanes(20000, -3, 7, -7, 19999, -19999, 0, 0);
        queue_lanes(100, -100, 50, -50, 0, 0, 0, 0);
        queue_lanes(50, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // Channel count zero acts as one lane, thresholds beyond full scale
        // keep the gate shut, maximum holds, zero makeup silences everything.
        program_regs(65535, 65535, 65535, 65535, 2097151, 2097151, 0, 0);
        queue_lanes(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768);
        queue_lanes(-32768, 5, 5, 5, 5, 5, 5, 5);
        drain();

        // Channel count above the lane count, zero thresholds (a silent frame
        // sits between them), the smallest nonzero attack pole and the largest makeup.
        program_regs(0, 0, 1, 65535, 0, 0, 131071, 15);
        queue_lanes(0, 0, 0, 0, 0, 0, 0, 0);
        queue_lanes(1, 0, 0, 0, 0, 0, 0, 0);
        queue_lanes(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767);
        queue_lanes(-1, 1, -2, 2, -3, 3, -4, 4);
        drain();

        // Open threshold at full scale: the most negative code reaches it but
        // never exceeds it, and anything smaller releases right away.
        program_regs(32768, 40000, 65535, 65535, 0, 0, 1024, 8);
        queue_lanes(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        queue_lanes(32767, -32767, 16384, -16384, 1, -1, 0, 0);
        drain();

        // Random part: a fresh register setting per phase, and the sender
        // stops at the end of each phase until every result is back. Some
        // phases run without any idling on either side.
        for (phase_idx = 0; phase_idx < RAND_PHASES; phase_idx++)
        begin
            steady_flow = (phase_idx % 4 == 2);
            program_random_setting();
            queue_random_phase(PHASE_ITEMS);
            drain();
        end

        // Give a stray extra result time to show up before judging.
        repeat (40) @(posedge clk);

        $display("covered %0d requests over %0d register settings, %0d results compared",
                 requests_taken, settings_used, results_seen);
        $display("gate opened on %0d frames, closed on %0d, held on %0d; gain rose %0d, fell %0d",
                 open_frames, close_frames, between_frames, gain_rises, gain_falls);
        if (mismatches > 10) $display("%0d mismatching fields in all", mismatches);
        if (mismatches == 0 && gated_frames_due.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, even with every gap and
    // stall at its longest.
    initial
    begin
        #20_000_000;
        $display("timeout with %0d of %0d requests taken and %0d results owed",
                 requests_taken, frames_queued, gated_frames_due.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
